>>> sv/tbvpd_pkg.sv
// shared types and constants of the preamble deframer
`timescale 1ns / 1ps
package tbvpd_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned HistW = 6;

  // start-of-message pattern, oldest bit first in the msb
  localparam logic [HistW-1:0] Preamble = 6'b101011;
  localparam logic [TimeW-1:0] ThreshReset = 16'd150;

  // one decided bit leaving the vote stage
  typedef struct packed {
    logic valid;
    logic value;
  } vote_bit_t;

  // one result item leaving the deframer
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_out;
    logic             eom;
  } result_t;

endpackage

>>> sv/tbvpd_vote.sv
// miss and hit counters with the per-interval majority decision
`timescale 1ns / 1ps
module tbvpd_vote
  import tbvpd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      miss_i,
  input  logic      last_i,
  output vote_bit_t bit_o
);

  logic [COUNT_WIDTH-1:0] miss_q, miss_d, hit_q, hit_d;
  logic [COUNT_WIDTH-1:0] miss_n, hit_n;

  always_comb begin
    miss_n = miss_q;
    hit_n  = hit_q;
    // saturate at all ones
    if (miss_i) begin
      if (miss_q != '1) miss_n = miss_q + COUNT_WIDTH'(1);
    end else begin
      if (hit_q != '1) hit_n = hit_q + COUNT_WIDTH'(1);
    end
    bit_o.valid = en_i & last_i;
    bit_o.value = (miss_n >= hit_n);
    miss_d = miss_q;
    hit_d  = hit_q;
    if (en_i) begin
      miss_d = last_i ? '0 : miss_n;
      hit_d  = last_i ? '0 : hit_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
      hit_q  <= '0;
    end else begin
      miss_q <= miss_d;
      hit_q  <= hit_d;
    end
  end

endmodule

>>> sv/tbvpd_deframer.sv
// preamble hunt, byte packing and end-of-message detection
`timescale 1ns / 1ps
module tbvpd_deframer
  import tbvpd_pkg::*;
#(
  parameter int unsigned MAX_MSG_BITS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vote_bit_t bit_i,
  output result_t   res_o
);

  localparam int unsigned MbW = $clog2(MAX_MSG_BITS + 1);
  localparam logic [MbW-1:0] LimitVal = MbW'(MAX_MSG_BITS);

  logic [HistW-1:0] hist_q, hist_d;
  logic             recv_q, recv_d;
  logic [MbW-1:0]   mb_q, mb_d, mb_n;
  logic [CharW-1:0] byte_q, byte_d, byte_n;
  logic             full, limit;

  always_comb begin
    hist_d = hist_q;
    recv_d = recv_q;
    mb_d   = mb_q;
    byte_d = byte_q;
    res_o  = '0;
    byte_n = {byte_q[CharW-2:0], bit_i.value};
    mb_n   = mb_q + MbW'(1);
    full   = (mb_n[2:0] == 3'd0);
    limit  = (mb_n >= LimitVal);
    if (bit_i.valid) begin
      if (!recv_q) begin
        // history only advances while hunting
        hist_d = {hist_q[HistW-2:0], bit_i.value};
        if (hist_d == Preamble) begin
          recv_d = 1'b1;
          mb_d   = '0;
          byte_d = '0;
        end
      end else begin
        byte_d = byte_n;
        mb_d   = mb_n;
        if (full && byte_n == '0) begin
          // null terminator
          res_o  = '{valid: 1'b1, char_out: '0, eom: 1'b1};
          recv_d = 1'b0;
          mb_d   = '0;
        end else if (limit) begin
          // bit limit, partial byte dropped
          res_o  = '{valid: 1'b1, char_out: (full ? byte_n : '0), eom: 1'b1};
          recv_d = 1'b0;
          mb_d   = '0;
          byte_d = '0;
        end else if (full) begin
          res_o  = '{valid: 1'b1, char_out: byte_n, eom: 1'b0};
          byte_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      recv_q <= 1'b0;
      mb_q   <= '0;
      byte_q <= '0;
    end else begin
      hist_q <= hist_d;
      recv_q <= recv_d;
      mb_q   <= mb_d;
      byte_q <= byte_d;
    end
  end

endmodule

>>> sv/timing_bit_vote_preamble_deframer.sv
// top level of the majority-vote preamble deframer
`timescale 1ns / 1ps
//
// channel   | direction | tdata            | tlast
// ----------+-----------+------------------+----------------
// s_axis    | in        | [15:0] probe_lat | window_end
// m_axis    | out       | [7:0] char_out   | end_of_message
// cfg       | in        | [15:0] threshold | -
//
// one item per cycle unless stalled: an item is registered on entry, then
// voted and deframed by short logic; its result lands in the output register
// a stalled output holds the result and the input register in place; the
// input stays ready as long as the output register is empty or being drained
// reset clears counters, preamble history and the receive state, and loads
// the miss threshold with 150
module timing_bit_vote_preamble_deframer
  import tbvpd_pkg::*;
#(
  parameter int unsigned MAX_MSG_BITS = 1024,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TimeW-1:0] cfg_wdata_i,   // hit_threshold
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [TimeW-1:0] s_axis_tdata,  // [15:0] probe_lat
  input  logic             s_axis_tlast,  // window_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,  // [7:0] char_out
  output logic             m_axis_tlast   // end_of_message
);

  logic [TimeW-1:0] thresh_q;

  // input register
  logic             st_valid_q;
  logic [TimeW-1:0] st_time_q;
  logic             st_last_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;
  logic             out_eom_q;

  logic      fire;
  vote_bit_t vote_bit;
  result_t   res;

  // stage moves when the output register can take whatever it produces
  assign fire          = st_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~st_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      st_time_q <= s_axis_tdata;
      st_last_q <= s_axis_tlast;
    end
  end

  tbvpd_vote #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_vote (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (fire),
    .miss_i(st_time_q > thresh_q),
    .last_i(st_last_q),
    .bit_o (vote_bit)
  );

  tbvpd_deframer #(
    .MAX_MSG_BITS(MAX_MSG_BITS)
  ) u_deframer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .bit_i (vote_bit),
    .res_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_char_q <= res.char_out;
      out_eom_q  <= res.eom;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_eom_q;

endmodule
